### hw/rtl/drskr_pkg.sv
// Shared types and constants for the dual-role shift key resolver
`timescale 1ns / 1ps
`default_nettype none

package drskr_pkg;

    // timer width default and configuration field widths
    localparam int TIME_BITS_DEFAULT = 16;
    localparam int CFG_TIME_W        = 16;
    localparam int APB_DATA_W        = 32;
    localparam int APB_ADDR_W        = 4;
    localparam int REG_IDX_W         = 2;

    // register reset values
    localparam logic [CFG_TIME_W-1:0] DELAY_RESET    = 16'd500;
    localparam logic [CFG_TIME_W-1:0] INTERVAL_RESET = 16'd40;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_DELAY    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_INTERVAL = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BSP_REP  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_QUO_REP  = 2'd3;

    // input operation codes
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // key classes
    typedef enum logic [1:0] {
        KEY_BSP     = 2'd0,
        KEY_QUO     = 2'd1,
        KEY_ORD     = 2'd2,
        KEY_SPECIAL = 2'd3
    } key_class_t;

    // result actions
    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_TAP_BSP  = 3'd1,
        ACT_TAP_QUO  = 3'd2,
        ACT_TAP_SQUO = 3'd3,
        ACT_LSFT_DN  = 3'd4,
        ACT_LSFT_UP  = 3'd5,
        ACT_RSFT_DN  = 3'd6,
        ACT_RSFT_UP  = 3'd7
    } action_t;

    // configuration as seen by the core
    typedef struct packed {
        logic [CFG_TIME_W-1:0] repeat_delay_ms;
        logic [CFG_TIME_W-1:0] repeat_interval_ms;
        logic                  backspace_repeat_enable;
        logic                  quote_repeat_enable;
    } cfg_t;

    // one or two results of an item, handed to the output stage
    typedef struct packed {
        action_t act0;
        action_t act1;
        logic    two;
        logic    pass;
    } pair_t;

endpackage

`default_nettype wire

### hw/rtl/drskr_if.sv
// Valid/ready channel interfaces for key items and result beats
`timescale 1ns / 1ps
`default_nettype none

interface drskr_in_if;
    logic                    valid;
    logic                    ready;
    logic                    op;
    drskr_pkg::key_class_t   key_class;
    logic                    pressed;
    logic                    host_shift;

    modport source (output valid, op, key_class, pressed, host_shift, input ready);
    modport sink   (input valid, op, key_class, pressed, host_shift, output ready);
endinterface

interface drskr_out_if;
    logic                  valid;
    logic                  ready;
    drskr_pkg::action_t    action;
    logic                  pass_through;
    logic                  last;

    modport source (output valid, action, pass_through, last, input ready);
    modport sink   (input valid, action, pass_through, last, output ready);
endinterface

`default_nettype wire

### hw/rtl/drskr_cfg.sv
// APB-style configuration registers
`timescale 1ns / 1ps
`default_nettype none

module drskr_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [drskr_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [drskr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [drskr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                   pready,
    output drskr_pkg::cfg_t                        cfg
);
    import drskr_pkg::*;

    logic [CFG_TIME_W-1:0] delay_reg;
    logic [CFG_TIME_W-1:0] interval_reg;
    logic                  bsp_rep_reg;
    logic                  quo_rep_reg;
    logic [REG_IDX_W-1:0]  idx;
    logic                  wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[APB_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg    <= DELAY_RESET;
            interval_reg <= INTERVAL_RESET;
            bsp_rep_reg  <= 1'b1;
            quo_rep_reg  <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_DELAY:    delay_reg    <= pwdata[CFG_TIME_W-1:0];
                REG_INTERVAL: interval_reg <= pwdata[CFG_TIME_W-1:0];
                REG_BSP_REP:  bsp_rep_reg  <= pwdata[0];
                REG_QUO_REP:  quo_rep_reg  <= pwdata[0];
                default:      ;
            endcase
        end
    end

    // read-back
    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_DELAY:    prdata[CFG_TIME_W-1:0] = delay_reg;
            REG_INTERVAL: prdata[CFG_TIME_W-1:0] = interval_reg;
            REG_BSP_REP:  prdata[0] = bsp_rep_reg;
            REG_QUO_REP:  prdata[0] = quo_rep_reg;
            default:      prdata = '0;
        endcase
    end

    assign cfg.repeat_delay_ms         = delay_reg;
    assign cfg.repeat_interval_ms      = interval_reg;
    assign cfg.backspace_repeat_enable = bsp_rep_reg;
    assign cfg.quote_repeat_enable     = quo_rep_reg;

endmodule

`default_nettype wire

### hw/rtl/drskr_core.sv
// Key state, repeat timers and result decision for one input beat
`timescale 1ns / 1ps
`default_nettype none

module drskr_core #(
    parameter int TIME_BITS = drskr_pkg::TIME_BITS_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    drskr_in_if.sink             in_ch,
    input  wire logic            in_free,
    input  wire drskr_pkg::cfg_t cfg,
    output logic                 pair_load,
    output drskr_pkg::pair_t     pair
);
    import drskr_pkg::*;

    localparam int CmpW = (TIME_BITS > CFG_TIME_W) ? TIME_BITS : CFG_TIME_W;

    logic                 bsp_held_reg, bsp_held_next;
    logic                 bsp_shift_reg, bsp_shift_next;
    logic [TIME_BITS-1:0] bsp_time_reg, bsp_time_next;
    logic [TIME_BITS-1:0] bsp_rep_reg, bsp_rep_next;
    logic                 quo_held_reg, quo_held_next;
    logic                 quo_shift_reg, quo_shift_next;
    logic [TIME_BITS-1:0] quo_time_reg, quo_time_next;
    logic [TIME_BITS-1:0] quo_rep_reg, quo_rep_next;
    logic                 quo_sap_reg, quo_sap_next;
    logic [1:0]           vsc_reg, vsc_next;

    logic                 accept;
    logic [1:0]           cnt;
    action_t              act0;
    action_t              act1;

    assign accept = in_ch.valid && in_free;

    function automatic logic [TIME_BITS-1:0] time_inc(input logic [TIME_BITS-1:0] t);
        time_inc = (t == {TIME_BITS{1'b1}}) ? t : t + TIME_BITS'(1);
    endfunction

    // next state and results of the beat
    always_comb
    begin
        bsp_held_next  = bsp_held_reg;
        bsp_shift_next = bsp_shift_reg;
        bsp_time_next  = bsp_time_reg;
        bsp_rep_next   = bsp_rep_reg;
        quo_held_next  = quo_held_reg;
        quo_shift_next = quo_shift_reg;
        quo_time_next  = quo_time_reg;
        quo_rep_next   = quo_rep_reg;
        quo_sap_next   = quo_sap_reg;
        vsc_next       = vsc_reg;
        cnt            = 2'd0;
        act0           = ACT_NONE;
        act1           = ACT_NONE;

        if (in_ch.op == OP_TICK)
        begin
            // advance timers, then repeat taps
            bsp_time_next = time_inc(bsp_time_reg);
            bsp_rep_next  = time_inc(bsp_rep_reg);
            quo_time_next = time_inc(quo_time_reg);
            quo_rep_next  = time_inc(quo_rep_reg);
            if (cfg.backspace_repeat_enable && bsp_held_reg && !bsp_shift_reg &&
                CmpW'(bsp_time_next) > CmpW'(cfg.repeat_delay_ms) &&
                CmpW'(bsp_rep_next) > CmpW'(cfg.repeat_interval_ms))
            begin
                act0         = ACT_TAP_BSP;
                cnt          = 2'd1;
                bsp_rep_next = '0;
            end
            if (cfg.quote_repeat_enable && quo_held_reg && !quo_shift_reg &&
                CmpW'(quo_time_next) > CmpW'(cfg.repeat_delay_ms) &&
                CmpW'(quo_rep_next) > CmpW'(cfg.repeat_interval_ms))
            begin
                if (cnt == 2'd0)
                    act0 = ACT_TAP_QUO;
                else
                    act1 = ACT_TAP_QUO;
                cnt          = cnt + 2'd1;
                quo_rep_next = '0;
            end
        end
        else
        begin
            // backspace-shift key, or a press that resolves it to left shift
            if (in_ch.key_class == KEY_BSP)
            begin
                if (in_ch.pressed)
                begin
                    bsp_held_next  = 1'b1;
                    bsp_shift_next = 1'b0;
                    bsp_time_next  = '0;
                    bsp_rep_next   = '0;
                end
                else
                begin
                    if (bsp_shift_reg)
                    begin
                        act0 = ACT_LSFT_UP;
                        if (vsc_next != 2'd0)
                            vsc_next = vsc_next - 2'd1;
                    end
                    else
                    begin
                        act0 = ACT_TAP_BSP;
                    end
                    cnt           = 2'd1;
                    bsp_held_next = 1'b0;
                end
            end
            else if (in_ch.pressed && bsp_held_reg && !bsp_shift_reg)
            begin
                act0           = ACT_LSFT_DN;
                cnt            = 2'd1;
                if (vsc_next != 2'd3)
                    vsc_next = vsc_next + 2'd1;
                bsp_shift_next = 1'b1;
            end

            // quote-shift key, or a press that resolves it to right shift
            if (in_ch.key_class == KEY_QUO)
            begin
                if (in_ch.pressed)
                begin
                    quo_held_next  = 1'b1;
                    quo_shift_next = 1'b0;
                    quo_time_next  = '0;
                    quo_rep_next   = '0;
                    quo_sap_next   = (vsc_next != 2'd0);
                end
                else
                begin
                    if (quo_shift_reg)
                    begin
                        act1 = ACT_RSFT_UP;
                        if (vsc_next != 2'd0)
                            vsc_next = vsc_next - 2'd1;
                    end
                    else if (!in_ch.host_shift && quo_sap_reg)
                    begin
                        act1 = ACT_TAP_SQUO;
                    end
                    else
                    begin
                        act1 = ACT_TAP_QUO;
                    end
                    cnt           = cnt + 2'd1;
                    quo_held_next = 1'b0;
                end
            end
            else if ((in_ch.key_class == KEY_BSP || in_ch.key_class == KEY_ORD) &&
                     in_ch.pressed && quo_held_reg && !quo_shift_reg)
            begin
                act1           = ACT_RSFT_DN;
                cnt            = cnt + 2'd1;
                if (vsc_next != 2'd3)
                    vsc_next = vsc_next + 2'd1;
                quo_shift_next = 1'b1;
            end

            // compact the quote result into the first slot when it stands alone
            if (cnt == 2'd1 && act0 == ACT_NONE)
            begin
                act0 = act1;
                act1 = ACT_NONE;
            end
            if (cnt == 2'd0)
                cnt = 2'd1;
        end
    end

    // key and timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bsp_held_reg  <= 1'b0;
            bsp_shift_reg <= 1'b0;
            bsp_time_reg  <= '0;
            bsp_rep_reg   <= '0;
            quo_held_reg  <= 1'b0;
            quo_shift_reg <= 1'b0;
            quo_time_reg  <= '0;
            quo_rep_reg   <= '0;
            quo_sap_reg   <= 1'b0;
            vsc_reg       <= 2'd0;
        end
        else if (accept)
        begin
            bsp_held_reg  <= bsp_held_next;
            bsp_shift_reg <= bsp_shift_next;
            bsp_time_reg  <= bsp_time_next;
            bsp_rep_reg   <= bsp_rep_next;
            quo_held_reg  <= quo_held_next;
            quo_shift_reg <= quo_shift_next;
            quo_time_reg  <= quo_time_next;
            quo_rep_reg   <= quo_rep_next;
            quo_sap_reg   <= quo_sap_next;
            vsc_reg       <= vsc_next;
        end
    end

    // results handed to the output stage
    assign pair_load = accept && (cnt != 2'd0);
    assign pair.act0 = act0;
    assign pair.act1 = act1;
    assign pair.two  = (cnt == 2'd2);
    assign pair.pass = (in_ch.op == OP_KEY) && (in_ch.key_class == KEY_ORD);

endmodule

`default_nettype wire

### hw/rtl/drskr_out.sv
// Result register that sends one or two result beats per item
`timescale 1ns / 1ps
`default_nettype none

module drskr_out (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             pair_load,
    input  wire drskr_pkg::pair_t pair,
    output logic                  free,
    drskr_out_if.source           out_ch
);
    import drskr_pkg::*;

    logic  valid_reg;
    logic  idx_reg;
    pair_t pair_reg;
    logic  last_beat;
    logic  beat_done;

    assign last_beat = !pair_reg.two || idx_reg;
    assign beat_done = valid_reg && out_ch.ready;
    assign free      = !valid_reg || (out_ch.ready && last_beat);

    // control: occupancy and beat index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end
        else if (pair_load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= 1'b0;
        end
        else if (beat_done)
        begin
            if (last_beat)
                valid_reg <= 1'b0;
            else
                idx_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (pair_load)
            pair_reg <= pair;
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.action       = idx_reg ? pair_reg.act1 : pair_reg.act0;
    assign out_ch.pass_through = pair_reg.pass;
    assign out_ch.last         = last_beat;

endmodule

`default_nettype wire

### hw/rtl/dual_role_shift_key_resolver.sv
// Top level of the dual-role shift key resolver
// The first result beat is presented in the cycle after the item is accepted.
// Throughput: one item per cycle when it gives one result and the receiver is ready; the
// result register sends one beat a cycle while ready and frees as its last beat goes.
// Ticks that give no result occupy no output slot.
// Reset: rst_n clears key state, timers and the result register; registers take defaults.
`timescale 1ns / 1ps
`default_nettype none

module dual_role_shift_key_resolver #(
    parameter int TIME_BITS = drskr_pkg::TIME_BITS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [drskr_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [drskr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [drskr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                   pready,
    drskr_in_if.sink                               in_ch,
    drskr_out_if.source                            out_ch
);
    import drskr_pkg::*;

    cfg_t  cfg;
    pair_t pair;
    logic  pair_load;
    logic  free;

    // configuration registers
    drskr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input beat accepted whenever the result register can take its results
    assign in_ch.ready = free;

    drskr_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .in_free   (free),
        .cfg       (cfg),
        .pair_load (pair_load),
        .pair      (pair)
    );

    drskr_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .pair_load (pair_load),
        .pair      (pair),
        .free      (free),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire

### tb/sv/drskr_checker.sv
// Result checker for the dual-role shift key resolver: tracks key state and compares beats
`timescale 1ns / 1ps

module drskr_checker #(
    parameter int TIME_BITS = drskr_pkg::TIME_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [drskr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [drskr_pkg::APB_DATA_W-1:0] pwdata,
    input  logic [drskr_pkg::APB_DATA_W-1:0] prdata,
    input  logic                             pready,
    drskr_in_if                              in_mon,
    drskr_out_if                             out_mon,
    output int                               errors,
    output int                               pending,
    output int                               checked
);
    import drskr_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef logic [TIME_BITS-1:0] ms_t;

    typedef struct packed {
        action_t action;
        logic    pass_through;
        logic    last;
    } beat_t;

    // register copies
    logic [CFG_TIME_W-1:0] delay_ms;
    logic [CFG_TIME_W-1:0] interval_ms;
    logic                  bk_rep_en;
    logic                  qt_rep_en;

    // key state copies
    logic       bk_down;
    logic       bk_is_shift;
    ms_t        bk_hold_ms;
    ms_t        bk_rep_ms;
    logic       qt_down;
    logic       qt_is_shift;
    ms_t        qt_hold_ms;
    ms_t        qt_rep_ms;
    logic       qt_shift_seen;
    logic [1:0] shift_level;

    beat_t                 due_beats [$];
    beat_t                 want;
    logic [APB_DATA_W-1:0] reg_word;

    // saturating millisecond counter step
    function automatic ms_t ms_step(input ms_t t);
        return (t == '1) ? t : t + ms_t'(1);
    endfunction

    // work out the beats one item causes and queue them
    task automatic resolve_item(input logic op, input key_class_t cls, input logic pressed,
                                input logic host);
        action_t acts [2];
        int      n;
        int      k;
        logic    thru;
        beat_t   b;
        n    = 0;
        thru = 1'b0;
        if (op == OP_TICK)
        begin
            bk_hold_ms = ms_step(bk_hold_ms);
            bk_rep_ms  = ms_step(bk_rep_ms);
            qt_hold_ms = ms_step(qt_hold_ms);
            qt_rep_ms  = ms_step(qt_rep_ms);
            // auto-repeat, backspace first
            if (bk_rep_en && bk_down && !bk_is_shift &&
                bk_hold_ms > delay_ms && bk_rep_ms > interval_ms)
            begin
                acts[n]   = ACT_TAP_BSP;
                n         = n + 1;
                bk_rep_ms = '0;
            end
            if (qt_rep_en && qt_down && !qt_is_shift &&
                qt_hold_ms > delay_ms && qt_rep_ms > interval_ms)
            begin
                acts[n]   = ACT_TAP_QUO;
                n         = n + 1;
                qt_rep_ms = '0;
            end
        end
        else
        begin
            // backspace key, or another press resolving it to left shift
            if (cls == KEY_BSP)
            begin
                if (pressed)
                begin
                    bk_down     = 1'b1;
                    bk_is_shift = 1'b0;
                    bk_hold_ms  = '0;
                    bk_rep_ms   = '0;
                end
                else
                begin
                    if (bk_is_shift)
                    begin
                        acts[n] = ACT_LSFT_UP;
                        n       = n + 1;
                        if (shift_level != 2'd0)
                            shift_level = shift_level - 2'd1;
                    end
                    else
                    begin
                        acts[n] = ACT_TAP_BSP;
                        n       = n + 1;
                    end
                    bk_down = 1'b0;
                end
            end
            else if (pressed && bk_down && !bk_is_shift)
            begin
                acts[n] = ACT_LSFT_DN;
                n       = n + 1;
                if (shift_level != 2'd3)
                    shift_level = shift_level + 2'd1;
                bk_is_shift = 1'b1;
            end

            // quote key, or a backspace or ordinary press resolving it to right shift
            if (cls == KEY_QUO)
            begin
                if (pressed)
                begin
                    qt_down       = 1'b1;
                    qt_is_shift   = 1'b0;
                    qt_hold_ms    = '0;
                    qt_rep_ms     = '0;
                    qt_shift_seen = (shift_level != 2'd0);
                end
                else
                begin
                    if (qt_is_shift)
                    begin
                        acts[n] = ACT_RSFT_UP;
                        n       = n + 1;
                        if (shift_level != 2'd0)
                            shift_level = shift_level - 2'd1;
                    end
                    else if (!host && qt_shift_seen)
                    begin
                        acts[n] = ACT_TAP_SQUO;
                        n       = n + 1;
                    end
                    else
                    begin
                        acts[n] = ACT_TAP_QUO;
                        n       = n + 1;
                    end
                    qt_down = 1'b0;
                end
            end
            else if (cls == KEY_BSP || cls == KEY_ORD)
            begin
                if (pressed && qt_down && !qt_is_shift)
                begin
                    acts[n] = ACT_RSFT_DN;
                    n       = n + 1;
                    if (shift_level != 2'd3)
                        shift_level = shift_level + 2'd1;
                    qt_is_shift = 1'b1;
                end
            end

            if (cls == KEY_ORD)
                thru = 1'b1;
            if (n == 0)
            begin
                acts[n] = ACT_NONE;
                n       = n + 1;
            end
        end

        for (k = 0; k < n; k++)
        begin
            b.action       = acts[k];
            b.pass_through = thru;
            b.last         = (k == n - 1);
            due_beats.push_back(b);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_ms      = DELAY_RESET;
            interval_ms   = INTERVAL_RESET;
            bk_rep_en     = 1'b1;
            qt_rep_en     = 1'b0;
            bk_down       = 1'b0;
            bk_is_shift   = 1'b0;
            bk_hold_ms    = '0;
            bk_rep_ms     = '0;
            qt_down       = 1'b0;
            qt_is_shift   = 1'b0;
            qt_hold_ms    = '0;
            qt_rep_ms     = '0;
            qt_shift_seen = 1'b0;
            shift_level   = 2'd0;
            due_beats.delete();
            errors        = 0;
            pending       = 0;
            checked       = 0;
        end
        else
        begin
            // result beat against the oldest expectation
            if (out_mon.valid && out_mon.ready)
            begin
                checked = checked + 1;
                if (due_beats.size() == 0)
                begin
                    errors = errors + 1;
                    if (errors <= MAX_REPORTS)
                        $display("checker: unexpected beat action %0d pass_through %b last %b",
                                 out_mon.action, out_mon.pass_through, out_mon.last);
                end
                else
                begin
                    want = due_beats.pop_front();
                    if (out_mon.action !== want.action ||
                        out_mon.pass_through !== want.pass_through ||
                        out_mon.last !== want.last)
                    begin
                        errors = errors + 1;
                        if (errors <= MAX_REPORTS)
                            $display("checker: beat %0d want %0d %b %b got %0d %b %b",
                                     checked, want.action, want.pass_through, want.last,
                                     out_mon.action, out_mon.pass_through, out_mon.last);
                    end
                end
            end

            // register access phase
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr[REG_IDX_W+1:2])
                        REG_DELAY:    delay_ms    = pwdata[CFG_TIME_W-1:0];
                        REG_INTERVAL: interval_ms = pwdata[CFG_TIME_W-1:0];
                        REG_BSP_REP:  bk_rep_en   = pwdata[0];
                        REG_QUO_REP:  qt_rep_en   = pwdata[0];
                        default:      ;
                    endcase
                end
                else
                begin
                    case (paddr[REG_IDX_W+1:2])
                        REG_DELAY:    reg_word = APB_DATA_W'(delay_ms);
                        REG_INTERVAL: reg_word = APB_DATA_W'(interval_ms);
                        REG_BSP_REP:  reg_word = APB_DATA_W'(bk_rep_en);
                        default:      reg_word = APB_DATA_W'(qt_rep_en);
                    endcase
                    if (prdata !== reg_word)
                    begin
                        errors = errors + 1;
                        if (errors <= MAX_REPORTS)
                            $display("checker: register %0d read expected %h, got %h",
                                     paddr[REG_IDX_W+1:2], reg_word, prdata);
                    end
                end
            end

            // accepted item beat
            if (in_mon.valid && in_mon.ready)
                resolve_item(in_mon.op, in_mon.key_class, in_mon.pressed, in_mon.host_shift);

            pending = due_beats.size();
        end
    end

endmodule

### tb/sv/tb.sv
// Testbench top for the dual-role shift key resolver: stimulus, register setup and verdict
`timescale 1ns / 1ps

module tb;

    import drskr_pkg::*;

    localparam int          CYCLE_LIMIT    = 1000000;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          HOLD_TICKS     = 40;
    localparam int          PRESSURE_PHASE = 1;
    localparam int          NUM_PHASES     = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    drskr_in_if  in_ch ();
    drskr_out_if out_ch ();

    int   errors;
    int   pending;
    int   checked;
    int   cycles;
    int   items_sent;
    int   settings_used;
    int   tx_max_gap;
    int   rx_max_stall;
    int   rx_stall;
    logic rx_hold;
    logic hold_go;
    logic stim_bk_down;
    logic stim_qt_down;

    // per-phase register settings and pacing
    logic [15:0] ph_delay    [NUM_PHASES] = '{16'd3, 16'd0, 16'hFFFF, 16'd10,
                                              16'd0, 16'hFFFF, 16'd6, 16'd0};
    logic [15:0] ph_interval [NUM_PHASES] = '{16'd2, 16'd0, 16'hFFFF, 16'd0,
                                              16'd5, 16'd0, 16'hFFFF, 16'd0};
    logic        ph_bk_en    [NUM_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    logic        ph_qt_en    [NUM_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
    int          ph_gap      [NUM_PHASES] = '{9, 0, 9, 9, 0, 9, 9, 9};
    int          ph_stall    [NUM_PHASES] = '{9, 0, 9, 0, 9, 9, 9, 9};
    int          ph_items    [NUM_PHASES] = '{220, 200, 150, 200, 200, 150, 200, 230};

    dual_role_shift_key_resolver dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    drskr_checker chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_mon  (in_ch),
        .out_mon (out_ch),
        .errors  (errors),
        .pending (pending),
        .checked (checked)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // cycle limit
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles = cycles + 1;
        end
        $display("timeout after %0d cycles, %0d beats still due", cycles, pending);
        $display("tb: errors");
        $finish;
    end

    // receiver: random stall after each beat, forced low during the long hold
    initial
    begin
        out_ch.ready = 1'b0;
        rx_stall     = 0;
        forever
        begin
            @(negedge clk);
            if (!rst_n || rx_hold)
                out_ch.ready <= 1'b0;
            else if (rx_stall > 0)
            begin
                out_ch.ready <= 1'b0;
                rx_stall = rx_stall - 1;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (out_ch.valid && out_ch.ready)
            rx_stall = $urandom_range(0, rx_max_stall);
    end

    // long receiver hold, counted on its own
    initial
    begin
        rx_hold = 1'b0;
        wait (hold_go);
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    // offer one item and wait for it to be accepted
    task automatic send_item(input logic op, input key_class_t cls, input logic pressed,
                             input logic host);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.op         <= op;
        in_ch.key_class  <= cls;
        in_ch.pressed    <= pressed;
        in_ch.host_shift <= host;
        do @(posedge clk); while (!in_ch.ready);
        items_sent = items_sent + 1;
        if (op == OP_KEY && cls == KEY_BSP)
            stim_bk_down = pressed;
        if (op == OP_KEY && cls == KEY_QUO)
            stim_qt_down = pressed;
    endtask

    // tick runs and ticks between key items, mostly dual-key press/release pairs, some noise
    task automatic send_random();
        int         r;
        int         burst;
        key_class_t cls;
        logic       pressed;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            burst = $urandom_range(4, 16);
            repeat (burst)
                send_item(OP_TICK, key_class_t'(2'($urandom_range(0, 3))),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        else if (r < 50)
            send_item(OP_TICK, key_class_t'(2'($urandom_range(0, 3))),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 32)
                cls = KEY_BSP;
            else if (r < 64)
                cls = KEY_QUO;
            else if (r < 88)
                cls = KEY_ORD;
            else
                cls = KEY_SPECIAL;
            pressed = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) < 8)
            begin
                if (cls == KEY_BSP)
                    pressed = !stim_bk_down;
                else if (cls == KEY_QUO)
                    pressed = !stim_qt_down;
            end
            send_item(OP_KEY, cls, pressed, 1'($urandom_range(0, 1)));
        end
    endtask

    // stop offering, wait for every due beat, then let the block settle
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // one register access: setup cycle then access cycle
    task automatic apb_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
                              input logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write all registers with junk in the unused bits, then read them back
    task automatic set_config(input logic [15:0] delay, input logic [15:0] interval,
                              input logic bk_en, input logic qt_en);
        apb_access(1'b1, REG_DELAY,    {16'($urandom), delay});
        apb_access(1'b1, REG_INTERVAL, {16'($urandom), interval});
        apb_access(1'b1, REG_BSP_REP,  {31'($urandom), bk_en});
        apb_access(1'b1, REG_QUO_REP,  {31'($urandom), qt_en});
        apb_access(1'b0, REG_DELAY,    '0);
        apb_access(1'b0, REG_INTERVAL, '0);
        apb_access(1'b0, REG_BSP_REP,  '0);
        apb_access(1'b0, REG_QUO_REP,  '0);
        settings_used = settings_used + 1;
    endtask

    initial
    begin
        int p;
        int mid;
        int target;
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_ch.valid      = 1'b0;
        in_ch.op         = OP_KEY;
        in_ch.key_class  = KEY_BSP;
        in_ch.pressed    = 1'b0;
        in_ch.host_shift = 1'b0;
        hold_go          = 1'b0;
        items_sent       = 0;
        settings_used    = 1;
        stim_bk_down     = 1'b0;
        stim_qt_down     = 1'b0;
        tx_max_gap       = 9;
        rx_max_stall     = 9;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part under reset register values
        send_item(OP_KEY,  KEY_BSP,     1'b0, 1'b0); // release of a key never pressed
        send_item(OP_KEY,  KEY_QUO,     1'b0, 1'b0);
        send_item(OP_KEY,  KEY_SPECIAL, 1'b1, 1'b1);
        send_item(OP_KEY,  KEY_ORD,     1'b1, 1'b0);
        send_item(OP_KEY,  KEY_ORD,     1'b0, 1'b1);
        send_item(OP_KEY,  KEY_BSP,     1'b1, 1'b0);
        send_item(OP_KEY,  KEY_ORD,     1'b1, 1'b0); // backspace becomes left shift
        send_item(OP_KEY,  KEY_BSP,     1'b1, 1'b0); // re-press while resolved
        send_item(OP_KEY,  KEY_SPECIAL, 1'b1, 1'b0); // special press resolves it again
        send_item(OP_KEY,  KEY_QUO,     1'b1, 1'b0); // virtual shift seen at press
        send_item(OP_KEY,  KEY_QUO,     1'b0, 1'b0); // shifted quote tap
        send_item(OP_KEY,  KEY_QUO,     1'b1, 1'b1);
        send_item(OP_KEY,  KEY_QUO,     1'b0, 1'b1); // host shift on, plain quote
        send_item(OP_KEY,  KEY_QUO,     1'b1, 1'b0);
        send_item(OP_KEY,  KEY_BSP,     1'b1, 1'b0); // backspace press resolves quote
        send_item(OP_KEY,  KEY_ORD,     1'b1, 1'b0); // shift count saturates
        send_item(OP_KEY,  KEY_QUO,     1'b0, 1'b0);
        send_item(OP_KEY,  KEY_BSP,     1'b0, 1'b0);
        send_item(OP_KEY,  KEY_BSP,     1'b0, 1'b0); // repeated shift releases hit zero
        send_item(OP_KEY,  KEY_BSP,     1'b0, 1'b0);
        send_item(OP_TICK, KEY_SPECIAL, 1'b1, 1'b1); // tick with nothing held
        send_item(OP_KEY,  KEY_BSP,     1'b1, 1'b0);
        send_item(OP_TICK, KEY_QUO,     1'b0, 1'b0);
        send_item(OP_KEY,  KEY_BSP,     1'b0, 1'b1);
        send_item(OP_KEY,  KEY_SPECIAL, 1'b0, 1'b1);
        drain();

        // random phases, one register setting each
        ph_delay[NUM_PHASES-1]    = 16'($urandom_range(0, 15));
        ph_interval[NUM_PHASES-1] = 16'($urandom_range(0, 7));
        ph_bk_en[NUM_PHASES-1]    = 1'($urandom_range(0, 1));
        ph_qt_en[NUM_PHASES-1]    = 1'($urandom_range(0, 1));
        for (p = 0; p < NUM_PHASES; p++)
        begin
            set_config(ph_delay[p], ph_interval[p], ph_bk_en[p], ph_qt_en[p]);
            tx_max_gap   = ph_gap[p];
            rx_max_stall = ph_stall[p];
            // receiver holds off while repeat taps keep coming
            if (p == PRESSURE_PHASE)
            begin
                send_item(OP_KEY, KEY_BSP, 1'b1, 1'b0);
                hold_go = 1'b1;
                repeat (HOLD_TICKS) send_item(OP_TICK, KEY_ORD, 1'b0, 1'b0);
                send_item(OP_KEY, KEY_BSP, 1'b0, 1'b0);
                drain();
            end
            mid    = items_sent + ph_items[p] / 2;
            target = items_sent + ph_items[p];
            while (items_sent < mid)
                send_random();
            drain();
            while (items_sent < target)
                send_random();
            drain();
        end
        repeat (10) @(posedge clk);

        $display("summary: %0d items over %0d register settings, %0d result beats compared",
                 items_sent, settings_used, checked);
        $display("summary: included a %0d-cycle receiver hold and back-to-back repeat taps",
                 HOLD_CYCLES);
        if (errors == 0 && pending == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
